@@ design/kvs_pkg.sv @@
package kvs_pkg;

    // Longest key the scanner compares.
    localparam int KEY_MAX_CHARS = 16;
    localparam int KEY_POS_W     = 5;
    localparam int KEY_IDX_W     = 4;

    // Depth of the queue between the classifier and the parser.
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_CNT_W   = 3;

    // Configuration port.
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHARS_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHARS_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_CAPACITY = 8'd3;

    // Special characters of the settings text.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_FF  = 8'hFF;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [2:0] {
        PH_LINE  = 3'd0,
        PH_KEY   = 3'd1,
        PH_SEP   = 3'd2,
        PH_VALUE = 3'd3,
        PH_WAIT  = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_NOTFOUND = 2'd2
    } t_kind;

    // One classified input transaction as it waits in the queue.
    typedef struct packed {
        logic                     first;
        logic                     has_byte;
        logic                     last;
        logic                     is_eot;
        logic                     is_eol;
        logic                     is_eq;
        logic [KEY_MAX_CHARS-1:0] key_match;
        logic [7:0]               data_byte;
    } t_item;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value_byte;
        logic [15:0] value_length;
        logic        final_res;
    } t_result;

    // Queue status seen by the classifier and the parser.
    typedef struct packed {
        logic full;
        logic head_valid;
    } t_queue_status;

endpackage

@@ design/kvs_front.sv @@
module kvs_front (
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_first,
    input  logic                               i_has_byte,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last,
    input  logic [8*kvs_pkg::KEY_MAX_CHARS-1:0] i_key_chars,
    input  kvs_pkg::t_queue_status             i_queue_status,
    output logic                               o_push,
    output kvs_pkg::t_item                     o_item
);
    import kvs_pkg::*;

    // Accept whenever the queue has room.
    assign o_ready = !i_queue_status.full;
    assign o_push  = i_valid && o_ready;

    // Classify the byte and compare it with every key character at once.
    always_comb begin
        o_item.first     = i_first;
        o_item.has_byte  = i_has_byte;
        o_item.last      = i_last;
        o_item.data_byte = i_data_byte;
        o_item.is_eot    = i_data_byte inside {CH_NUL, CH_SUB, CH_FF};
        o_item.is_eol    = i_data_byte inside {CH_LF, CH_CR};
        o_item.is_eq     = (i_data_byte == CH_EQ);
        for (int p = 0; p < KEY_MAX_CHARS; p++) begin
            o_item.key_match[p] = (i_key_chars[p*8 +: 8] == i_data_byte);
        end
    end

endmodule

@@ design/kvs_queue.sv @@
module kvs_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  kvs_pkg::t_item         i_item,
    input  logic                   i_pop,
    output kvs_pkg::t_item         o_head,
    output kvs_pkg::t_queue_status o_status
);
    import kvs_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.full       = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.head_valid = (r_count != '0);

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/kvs_back.sv @@
module kvs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [4:0]             i_key_length,
    input  logic [15:0]            i_value_capacity,
    input  kvs_pkg::t_item         i_head,
    input  kvs_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output kvs_pkg::t_result       o_result
);
    import kvs_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [KEY_POS_W-1:0]   r_kpos, n_kpos;
    logic [15:0]            r_vcnt, n_vcnt;
    t_result                r_out, r_pend;
    logic                   r_out_valid, r_pend_valid;

    logic [KEY_POS_W-1:0]   s_len;
    logic [KEY_POS_W-1:0]   s_kpos_inc;
    logic                   s_done;
    t_result                s_res0, s_res1;
    logic [1:0]             s_res_cnt;
    logic                   s_load;

    // Result that closes a scan: found in a value, otherwise not found.
    function automatic t_result f_finish(input t_phase ph, input logic [15:0] cnt);
        t_result res;
        res.value_byte = '0;
        res.final_res  = 1'b1;
        if (ph == PH_VALUE) begin
            res.kind         = KIND_FOUND;
            res.value_length = cnt;
        end else begin
            res.kind         = KIND_NOTFOUND;
            res.value_length = '0;
        end
        return res;
    endfunction

    // Key lengths beyond the compare width act as the full width.
    assign s_len = (i_key_length > KEY_POS_W'(KEY_MAX_CHARS)) ?
                   KEY_POS_W'(KEY_MAX_CHARS) : i_key_length;

    // The head transaction is taken when both its results have a place.
    assign s_load = (!r_out_valid || i_ready) && !r_pend_valid;
    assign o_pop  = i_queue_status.head_valid && s_load;

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_kpos  <= '0;
            r_vcnt  <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_kpos  <= n_kpos;
            r_vcnt  <= n_vcnt;
        end
    end

    // Next parser state and the results of the head transaction.
    always_comb begin
        n_phase    = i_head.first ? PH_LINE : r_phase;
        n_kpos     = i_head.first ? '0 : r_kpos;
        n_vcnt     = i_head.first ? '0 : r_vcnt;
        s_done     = 1'b0;
        s_res0     = '0;
        s_res1     = '0;
        s_res_cnt  = 2'd0;
        s_kpos_inc = '0;
        if (n_phase == PH_DONE) begin
            s_done = 1'b1;
        end else if (s_len == '0) begin
            s_res0    = f_finish(n_phase, n_vcnt);
            s_res_cnt = 2'd1;
            n_phase   = PH_DONE;
            s_done    = 1'b1;
        end else if (i_head.has_byte) begin
            if (i_head.is_eot) begin
                s_res0    = f_finish(n_phase, n_vcnt);
                s_res_cnt = 2'd1;
                n_phase   = PH_DONE;
                s_done    = 1'b1;
            end else if (i_head.is_eol) begin
                if (n_phase == PH_VALUE) begin
                    s_res0    = f_finish(n_phase, n_vcnt);
                    s_res_cnt = 2'd1;
                    n_phase   = PH_DONE;
                    s_done    = 1'b1;
                end else begin
                    n_phase = PH_LINE;
                end
            end else begin
                case (n_phase)
                    PH_LINE, PH_KEY: begin
                        if (n_phase == PH_LINE) begin
                            n_kpos = '0;
                        end
                        if (i_head.key_match[n_kpos[KEY_IDX_W-1:0]]) begin
                            s_kpos_inc = n_kpos + 1'b1;
                            n_kpos     = s_kpos_inc;
                            n_phase    = (s_kpos_inc >= s_len) ? PH_SEP : PH_KEY;
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_SEP: begin
                        n_phase = i_head.is_eq ? PH_VALUE : PH_WAIT;
                    end
                    PH_VALUE: begin
                        if (n_vcnt >= i_value_capacity) begin
                            s_res0    = f_finish(n_phase, n_vcnt);
                            s_res_cnt = 2'd1;
                            n_phase   = PH_DONE;
                            s_done    = 1'b1;
                        end else begin
                            s_res0.kind         = KIND_BYTE;
                            s_res0.value_byte   = i_head.data_byte;
                            s_res0.value_length = '0;
                            s_res0.final_res    = 1'b0;
                            s_res_cnt           = 2'd1;
                            n_vcnt              = n_vcnt + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        // The last flag closes a scan that is still open.
        if (i_head.last && !s_done) begin
            if (s_res_cnt == 2'd0) begin
                s_res0    = f_finish(n_phase, n_vcnt);
                s_res_cnt = 2'd1;
            end else begin
                s_res1    = f_finish(n_phase, n_vcnt);
                s_res_cnt = 2'd2;
            end
            n_phase = PH_DONE;
        end
    end

    // Output register with one pending slot for a second result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (o_pop && s_res_cnt != 2'd0) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (s_res_cnt == 2'd2);
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (o_pop) begin
                r_out  <= s_res0;
                r_pend <= s_res1;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ design/key_value_line_scanner_unit.sv @@
// Scans a settings text, one byte per input transaction, for a line "key=value" whose
// key starts in the first column, and streams out the bytes of the first matching value,
// then one found result with the value length or one not-found result. A classifier takes one
// input transaction per cycle, while the queue has room, into a four-entry queue; the parser
// drains it at one transaction per cycle, while the output takes results, into an output
// register with a spare slot, so the sustained rate is one input per cycle while each input
// yields at most one result; one yielding a value byte and the closing result also fills the
// slot. Configuration writes are accepted every cycle and must be made while idle.
module key_value_line_scanner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kvs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [kvs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_first,
    input  logic                        i_has_byte,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_value_byte,
    output logic [15:0]                 o_value_length,
    output logic                        o_final_res
);
    import kvs_pkg::*;

    logic [8*KEY_MAX_CHARS-1:0] r_key_chars;
    logic [4:0]                 r_key_length;
    logic [15:0]                r_value_capacity;

    t_queue_status              s_queue_status;
    t_item                      s_item;
    t_item                      s_head;
    logic                       s_push;
    logic                       s_pop;
    t_result                    s_result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_chars      <= '0;
            r_key_length     <= '0;
            r_value_capacity <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_CHARS_LOW:  r_key_chars[63:0]   <= i_cfg_data;
                CFG_KEY_CHARS_HIGH: r_key_chars[127:64] <= i_cfg_data;
                CFG_KEY_LENGTH:     r_key_length        <= i_cfg_data[4:0];
                CFG_VALUE_CAPACITY: r_value_capacity    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Classifier.
    kvs_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first        (i_first),
        .i_has_byte     (i_has_byte),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_key_chars    (r_key_chars),
        .i_queue_status (s_queue_status),
        .o_push         (s_push),
        .o_item         (s_item)
    );

    // Queue between classifier and parser.
    kvs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_item   (s_item),
        .i_pop    (s_pop),
        .o_head   (s_head),
        .o_status (s_queue_status)
    );

    // Parser and result output.
    kvs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_key_length     (r_key_length),
        .i_value_capacity (r_value_capacity),
        .i_head           (s_head),
        .i_queue_status   (s_queue_status),
        .o_pop            (s_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result         (s_result)
    );

    assign o_kind         = s_result.kind;
    assign o_value_byte   = s_result.value_byte;
    assign o_value_length = s_result.value_length;
    assign o_final_res    = s_result.final_res;

endmodule
